### sv/bfsa_pkg.sv
// shared types and constants for the best-fit free segment allocator
// no dependencies; imported by the segment cell and the top level
package bfsa_pkg;

  localparam int MAX_SEGMENTS = 16;
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);

  localparam logic [15:0] GROW_RESET   = 16'd4096;
  localparam logic [7:0]  HEADER_RESET = 8'd32;

  // register indexes
  localparam logic [1:0] REG_GROW   = 2'd0;
  localparam logic [1:0] REG_HEADER = 2'd1;
  localparam logic [1:0] REG_BASE   = 2'd2;

  // operation and status codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_TOOBIG   = 2'd2;
  localparam logic [1:0] ST_OK_GROWN = 2'd3;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL
  } cell_cmd_t;

  // broadcast control to every cell of the chain
  typedef struct packed {
    cell_cmd_t   cmd;
    logic [16:0] key;
    logic [31:0] new_base;
    logic [15:0] new_size;
  } cell_ctl_t;

  typedef struct packed {
    logic        op;
    logic [15:0] req_size;
    logic [31:0] free_addr;
    logic [15:0] free_size;
  } in_word_t;

  typedef struct packed {
    logic [31:0] block_addr;
    logic [1:0]  status;
    logic [4:0]  segment_count;
  } out_word_t;

endpackage

### sv/bfsa_cell.sv
// one slot of the sorted free-segment chain: holds a base and a size
// depends on bfsa_pkg; shifts from its left or right neighbor on insert or delete
module bfsa_cell (
  input  logic               clk,
  input  bfsa_pkg::cell_ctl_t ctl,
  input  logic               valid,
  input  logic               prev_lt,
  input  logic [31:0]        left_base,
  input  logic [15:0]        left_size,
  input  logic [31:0]        right_base,
  input  logic [15:0]        right_size,
  output logic [31:0]        base,
  output logic [15:0]        size,
  output logic               lt,
  output logic               fit
);
  import bfsa_pkg::*;

  // ordering flags against the broadcast key
  assign lt  = valid && ({1'b0, size} < ctl.key);
  assign fit = valid && ({1'b0, size} >= ctl.key);

  // insert: keep if smaller, take new word at the boundary, else shift right
  // delete: everything from the first fit onward takes its right neighbor
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CMD_INS: begin
        if (!lt) begin
          if (prev_lt) begin
            base <= ctl.new_base;
            size <= ctl.new_size;
          end else begin
            base <= left_base;
            size <= left_size;
          end
        end
      end
      CMD_DEL: begin
        if (fit) begin
          base <= right_base;
          size <= right_size;
        end
      end
      default: ;
    endcase
  end

endmodule

### sv/best_fit_free_segment_allocator_unit.sv
// top level of the best-fit free segment allocator
// depends on bfsa_pkg and bfsa_cell (a chain of MAX_SEGMENTS cells)
//
// usage:
//   input channel in_valid/in_ready carries one word (op, req_size,
//   free_addr, free_size); output channel out_valid/out_ready returns one
//   word (block_addr, status, segment_count) for every input word.
//   the cfg port writes grow_bytes, header_bytes and heap_base (which is
//   the break pointer); the user writes only while idle, unenforced by the block.
// sequencing:
//   one word is processed at a time. a free runs S_INS then S_DONE (only
//   S_DONE if the table is full); an allocate runs S_FIT, then S_INS if a
//   remainder is left, then S_DONE; growing the heap adds S_INS and S_FIT
//   again. S_DONE waits for the output register to empty. S_FIT is a fit
//   search with delete, S_INS a sorted insert, all cells shifting in parallel.
//   the next word is accepted once the result sits in the output register,
//   so a stalled receiver holds only the following item, not this one.
// reset:
//   synchronous rst empties the table, loads register reset values and sets
//   the break pointer to zero; no clearing pass is needed.
module best_fit_free_segment_allocator_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bfsa_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bfsa_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import bfsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIT,
    S_INS,
    S_DONE
  } state_t;

  state_t          state;
  logic [15:0]     grow_bytes;
  logic [7:0]      header_bytes;
  logic [31:0]     break_addr;
  logic [CNT_W-1:0] count;
  logic [16:0]     need;
  logic [31:0]     ins_base;
  logic [15:0]     ins_size;
  logic            grown;
  logic            fit_after;
  logic [31:0]     res_addr;
  logic [1:0]      res_status;

  cell_ctl_t   ctl;
  logic [31:0] cbase [MAX_SEGMENTS];
  logic [15:0] csize [MAX_SEGMENTS];
  logic        clt   [MAX_SEGMENTS];
  logic        cfit  [MAX_SEGMENTS];
  logic        cval  [MAX_SEGMENTS];

  logic        any_fit;
  logic [31:0] fit_base;
  logic [15:0] fit_size;
  logic [16:0] grow_room;
  logic        too_big;

  // chain of cells
  for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
    assign cval[i] = (CNT_W'(i) < count);
    bfsa_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (cval[i]),
      .prev_lt    ((i == 0) ? 1'b1 : clt[(i == 0) ? 0 : i - 1]),
      .left_base  (cbase[(i == 0) ? 0 : i - 1]),
      .left_size  (csize[(i == 0) ? 0 : i - 1]),
      .right_base (cbase[(i == MAX_SEGMENTS - 1) ? i : i + 1]),
      .right_size (csize[(i == MAX_SEGMENTS - 1) ? i : i + 1]),
      .base       (cbase[i]),
      .size       (csize[i]),
      .lt         (clt[i]),
      .fit        (cfit[i])
    );
  end

  // first fitting cell: fit flags rise once along the sorted chain
  always_comb begin
    any_fit  = 1'b0;
    fit_base = '0;
    fit_size = '0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      if (cfit[i] && (i == 0 || !cfit[(i == 0) ? 0 : i - 1])) begin
        fit_base = fit_base | cbase[i];
        fit_size = fit_size | csize[i];
      end
      any_fit = any_fit | cfit[i];
    end
  end

  // growth segment size and the never-fits test
  assign grow_room = {1'b0, grow_bytes} - {9'b0, header_bytes};
  assign too_big   = ({1'b0, grow_bytes} < {9'b0, header_bytes}) || (need > grow_room);

  // chain control
  always_comb begin
    ctl.new_base = ins_base;
    ctl.new_size = ins_size;
    if (state == S_INS) begin
      ctl.cmd = CMD_INS;
      ctl.key = {1'b0, ins_size};
    end else if (state == S_FIT && any_fit) begin
      ctl.cmd = CMD_DEL;
      ctl.key = need;
    end else begin
      ctl.cmd = CMD_HOLD;
      ctl.key = need;
    end
  end

  assign in_ready = (state == S_IDLE);

  // sequencer, registers and output word
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      grow_bytes   <= GROW_RESET;
      header_bytes <= HEADER_RESET;
      break_addr   <= '0;
      count        <= '0;
      out_valid    <= 1'b0;
      grown        <= 1'b0;
      fit_after    <= 1'b0;
    end else begin
      // output word taken and no new one loaded this cycle
      if (out_valid && out_ready && state != S_DONE) out_valid <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_GROW:   grow_bytes <= cfg_data[15:0];
          REG_HEADER: header_bytes <= cfg_data[7:0];
          REG_BASE:   break_addr <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            need       <= {1'b0, in_data.req_size} + {9'b0, header_bytes};
            res_addr   <= '0;
            grown      <= 1'b0;
            fit_after  <= 1'b0;
            ins_base   <= in_data.free_addr + {24'b0, header_bytes};
            ins_size   <= in_data.free_size;
            if (in_data.op == OP_FREE) begin
              if (count == CNT_W'(MAX_SEGMENTS)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                res_status <= ST_OK;
                state      <= S_INS;
              end
            end else begin
              res_status <= ST_OK;
              state      <= S_FIT;
            end
          end
        end
        S_FIT: begin
          if (any_fit) begin
            res_addr   <= fit_base;
            res_status <= grown ? ST_OK_GROWN : ST_OK;
            count      <= count - CNT_W'(1);
            ins_base   <= fit_base + {15'b0, need};
            ins_size   <= fit_size - need[15:0];
            fit_after  <= 1'b0;
            state      <= ({1'b0, fit_size} != need) ? S_INS : S_DONE;
          end else if (too_big || grown) begin
            res_status <= ST_TOOBIG;
            state      <= S_DONE;
          end else if (count == CNT_W'(MAX_SEGMENTS)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            ins_base   <= break_addr + {24'b0, header_bytes};
            ins_size   <= grow_room[15:0];
            break_addr <= break_addr + {16'b0, grow_bytes};
            grown      <= 1'b1;
            fit_after  <= 1'b1;
            state      <= S_INS;
          end
        end
        S_INS: begin
          count <= count + CNT_W'(1);
          state <= fit_after ? S_FIT : S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.block_addr    <= res_addr;
            out_data.status        <= res_status;
            out_data.segment_count <= 5'(count);
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/testbench.sv
// self-checking testbench for best_fit_free_segment_allocator_unit
// depends on bfsa_pkg and the allocator rtl; keeps its own model of the sorted free table
`timescale 1ns / 1ps

module testbench;
  import bfsa_pkg::*;

  localparam int N_RANDOM    = 1800;
  localparam int CYCLE_LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  best_fit_free_segment_allocator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the free table and registers
  logic [31:0] tbl_base [MAX_SEGMENTS];
  logic [15:0] tbl_size [MAX_SEGMENTS];
  int          tbl_count;
  logic [31:0] brk;
  logic [15:0] grow_r;
  logic [7:0]  hdr_r;

  out_word_t pending_q [$];
  int  errors = 0;
  int  cycles = 0;
  bit  stall_mode = 1'b0;

  function automatic void tbl_clear();
    tbl_count = 0;
    brk = 32'd0;
    grow_r = GROW_RESET;
    hdr_r = HEADER_RESET;
  endfunction

  function automatic bit tbl_insert(logic [31:0] b, logic [16:0] s);
    int p;
    p = 0;
    if (tbl_count >= MAX_SEGMENTS) return 1'b0;
    while (p < tbl_count && {1'b0, tbl_size[p]} < s) p++;
    for (int i = tbl_count; i > p; i--) begin
      tbl_base[i] = tbl_base[i-1];
      tbl_size[i] = tbl_size[i-1];
    end
    tbl_base[p] = b;
    tbl_size[p] = s[15:0];
    tbl_count++;
    return 1'b1;
  endfunction

  function automatic bit tbl_take(logic [16:0] need, output logic [31:0] a);
    logic [31:0] b;
    logic [16:0] s;
    a = '0;
    for (int i = 0; i < tbl_count; i++) begin
      if ({1'b0, tbl_size[i]} >= need) begin
        b = tbl_base[i];
        s = {1'b0, tbl_size[i]};
        a = b;
        for (int j = i; j + 1 < tbl_count; j++) begin
          tbl_base[j] = tbl_base[j+1];
          tbl_size[j] = tbl_size[j+1];
        end
        tbl_count--;
        if (s != need) void'(tbl_insert(b + 32'(need), s - need));
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // expected result word for one request
  function automatic out_word_t alloc_predict(in_word_t w);
    out_word_t r;
    logic [16:0] need;
    logic [31:0] a;
    r = '0;
    if (w.op == OP_FREE) begin
      if (!tbl_insert(w.free_addr + 32'(hdr_r), {1'b0, w.free_size})) r.status = ST_FULL;
    end else begin
      need = 17'(w.req_size) + 17'(hdr_r);
      if (tbl_take(need, a)) begin
        r.block_addr = a;
      end else if (grow_r < 16'(hdr_r) || need > 17'(grow_r - 16'(hdr_r))) begin
        r.status = ST_TOOBIG;
      end else if (!tbl_insert(brk + 32'(hdr_r), 17'(grow_r - 16'(hdr_r)))) begin
        r.status = ST_FULL;
      end else begin
        brk = brk + 32'(grow_r);
        if (tbl_take(need, a)) begin
          r.block_addr = a;
          r.status = ST_OK_GROWN;
        end else begin
          r.status = ST_TOOBIG;
        end
      end
    end
    r.segment_count = 5'(tbl_count);
    return r;
  endfunction

  // receiver: stall pattern and result check
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      if (out_valid && out_ready) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, out_data);
          errors++;
        end else begin
          if (out_data.block_addr !== pending_q[0].block_addr)
            $display("%0t: block_addr exp %h got %h", $time,
                     pending_q[0].block_addr, out_data.block_addr);
          if (out_data.status !== pending_q[0].status)
            $display("%0t: status exp %0d got %0d", $time,
                     pending_q[0].status, out_data.status);
          if (out_data.segment_count !== pending_q[0].segment_count)
            $display("%0t: segment_count exp %0d got %0d", $time,
                     pending_q[0].segment_count, out_data.segment_count);
          if (out_data !== pending_q[0]) errors++;
          void'(pending_q.pop_front());
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one request word through the handshake; expected word typed in when given
  task automatic send_word(in_word_t w, bit typed, out_word_t exp_w);
    out_word_t p;
    p = alloc_predict(w);
    if (typed && p !== exp_w) begin
      $display("%0t: table row exp %h model %h", $time, exp_w, p);
      errors++;
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(p);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  task automatic send_paced(in_word_t w);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    send_word(w, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GROW:   grow_r = v[15:0];
      REG_HEADER: hdr_r = v[7:0];
      REG_BASE:   brk = v;
      default: ;
    endcase
  endtask

  function automatic in_word_t mk(logic o, logic [15:0] rq, logic [31:0] fa, logic [15:0] fs);
    in_word_t w;
    w.op = o; w.req_size = rq; w.free_addr = fa; w.free_size = fs;
    return w;
  endfunction

  function automatic out_word_t ex(logic [31:0] a, logic [1:0] s, logic [4:0] c);
    out_word_t r;
    r.block_addr = a; r.status = s; r.segment_count = c;
    return r;
  endfunction

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t e;
  } stim_row_t;

  stim_row_t rows [$];
  in_word_t  w;
  logic [15:0] sizes [$];

  initial begin
    tbl_clear();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, reset registers (grow 4096, header 32, break 0)
    rows.push_back('{mk(OP_ALLOC, 16'd100, 0, 0), 1, ex(32'd32, ST_OK_GROWN, 5'd1)});
    rows.push_back('{mk(OP_ALLOC, 16'd4064, 0, 0), 1, ex(32'd0, ST_TOOBIG, 5'd1)});
    rows.push_back('{mk(OP_ALLOC, 16'hFFFF, 0, 0), 1, ex(32'd0, ST_TOOBIG, 5'd1)});
    rows.push_back('{mk(OP_FREE, 0, 32'hFFFF_FFF0, 16'hFFFF), 1, ex(0, ST_OK, 5'd2)});
    rows.push_back('{mk(OP_FREE, 0, 32'd0, 16'd0), 1, ex(0, ST_OK, 5'd3)});
    rows.push_back('{mk(OP_ALLOC, 16'd0, 0, 0), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 16'hFFDF, 0, 0), 0, '0});
    rows.push_back('{mk(OP_ALLOC, 16'd4000, 0, 0), 0, '0});
    for (int i = 0; i < 16; i++)
      rows.push_back('{mk(OP_FREE, 0, $urandom, 16'(i * 8)), 0, '0});
    rows.push_back('{mk(OP_FREE, 0, 32'h5555_AAAA, 16'h1234), 0, '0});
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].e);
    drain();

    // allocate growth with full table, then free everything out by allocating
    send_word(mk(OP_ALLOC, 16'hF000, 0, 0), 0, '0);
    for (int i = 0; i < 20; i++) send_word(mk(OP_ALLOC, 16'd0, 0, 0), 0, '0);
    drain();

    // random phases through several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(REG_GROW, 32'd64); write_reg(REG_HEADER, 32'd0);
                 write_reg(REG_BASE, 32'hFFFF_FF00); end
        1: begin write_reg(REG_GROW, 32'd65535); write_reg(REG_HEADER, 32'd255);
                 write_reg(REG_BASE, 32'd0); end
        2: begin write_reg(REG_GROW, 32'd100); write_reg(REG_HEADER, 32'd200); end
        3: begin write_reg(REG_GROW, 32'd4096); write_reg(REG_HEADER, 32'd32);
                 write_reg(REG_BASE, 32'hFFFF_FFFF); end
        4: begin write_reg(REG_GROW, $urandom_range(64, 65535));
                 write_reg(REG_HEADER, $urandom_range(0, 255));
                 write_reg(REG_BASE, $urandom); end
        default: begin write_reg(REG_GROW, 32'd1024); write_reg(REG_HEADER, 32'd16); end
      endcase
      stall_mode = (ph % 2 == 1);
      for (int n = 0; n < N_RANDOM / 6; n++) begin
        // mostly allocate/free pairs of realistic sizes, some raw noise
        if ($urandom_range(0, 9) == 0) begin
          w = mk(1'($urandom), 16'($urandom), $urandom, 16'($urandom));
        end else if ($urandom_range(0, 1) == 0 || sizes.size() == 0) begin
          w = mk(OP_ALLOC, 16'($urandom_range(0, 32'(grow_r) + 20)), 0, 0);
          sizes.push_back(w.req_size);
        end else begin
          w = mk(OP_FREE, 0, $urandom, sizes.pop_front());
        end
        send_paced(w);
        if (n == 100) drain();
      end
      drain();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
sv/bfsa_pkg.sv
sv/bfsa_cell.sv
sv/best_fit_free_segment_allocator_unit.sv
bench/testbench.sv
